[hdl/dxtbd_pkg.sv]
package dxtbd_pkg;

  // block_format register codes
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Reciprocal constants for exact small-value division
  localparam logic [9:0]  RECIP3 = 10'd683;   // x/3 = (x*683) >> 11, x <= 765
  localparam logic [11:0] RECIP5 = 12'd3277;  // x/5 = (x*3277) >> 14, x <= 1275
  localparam logic [11:0] RECIP7 = 12'd2341;  // x/7 = (x*2341) >> 14, x <= 1785

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 136;

  // One palette color, 8 bits per channel
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

[hdl/dxt_block_decoder.sv]
// DXT (BC1/BC2/BC3) block decoder.
// in_*  : one request per compressed 4x4 block. in_tdata[63:0] holds block
//         bytes 0..7, in_tdata[127:64] bytes 8..15 (little-endian).
// out_* : four requests per block, one per texel row, top row first. Each
//         carries the row index and four ARGB8888 texels; out_tlast marks row 3.
// cfg_* : cfg_wr_en writes block_format (0 DXT1, 1 DXT3, 2 DXT5, 3 as DXT1).
//         Write it only while the block holds no work.
// Pipeline: input register -> palette register (endpoints, interpolated
// colors, alpha table) -> row output register. The first row of a block
// passes through the input, palette and row output registers in order; the
// other rows follow while the receiver keeps out_tready high. The row
// sequencer emits one row per cycle while out_tready allows. The input
// register takes the next block while the current one is still being
// emitted.
// Reset (rst_n low, synchronous) empties all stages and sets format to DXT1.
// When out_tready is low the current row holds, the sequencer stops, and
// in_tready drops once the input and palette registers are both occupied.
module dxt_block_decoder (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_wr_data,
  // compressed blocks
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // [63:0] block_low, [127:64] block_high
  // decoded rows
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,   // [1:0] row_index, [33:2] texel_col0,
                                    // [65:34] texel_col1, [97:66] texel_col2,
                                    // [129:98] texel_col3, [135:130] zero
  output logic         out_tlast    // last_row
);

  // ---------------------------------------------------------------
  // Small constant divisions
  // ---------------------------------------------------------------
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(dxtbd_pkg::RECIP3);
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(dxtbd_pkg::RECIP5);
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(dxtbd_pkg::RECIP7);
    return p[21:14];
  endfunction

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [1:0] block_format_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_format_r <= dxtbd_pkg::FMT_DXT1;
    end else if (cfg_wr_en) begin
      block_format_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------
  logic       a_valid_r;
  logic       b_valid_r;
  logic       out_valid_r;
  logic [1:0] row_r;
  logic       out_free;
  logic       emit;
  logic       b_last;
  logic       a_take;

  assign out_free  = !out_valid_r || out_tready;
  assign emit      = b_valid_r && out_free;
  assign b_last    = emit && (row_r == 2'd3);
  assign a_take    = a_valid_r && (!b_valid_r || b_last);
  assign in_tready = !a_valid_r || a_take;

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic [63:0] blk_lo_r;
  logic [63:0] blk_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      blk_lo_r <= in_tdata[63:0];
      blk_hi_r <= in_tdata[127:64];
    end
  end

  // ---------------------------------------------------------------
  // Palette computation from the input register
  // ---------------------------------------------------------------
  logic            has_alpha;
  logic [63:0]     cblk;
  logic [15:0]     c0;
  logic [15:0]     c1;
  logic            three_nxt;
  dxtbd_pkg::rgb_t pal_nxt [4];
  logic [7:0]      a0;
  logic [7:0]      a1;
  logic [7:0]      atab_nxt [8];
  logic [9:0]      s2r, s2g, s2b, s3r, s3g, s3b;
  logic [8:0]      hr, hg, hb;
  logic [10:0]     asum;

  always_comb begin
    has_alpha = (block_format_r == dxtbd_pkg::FMT_DXT3) ||
                (block_format_r == dxtbd_pkg::FMT_DXT5);
    cblk      = has_alpha ? blk_hi_r : blk_lo_r;
    c0        = cblk[15:0];
    c1        = cblk[31:16];
    three_nxt = (c0 <= c1);

    // endpoints expanded from RGB565
    pal_nxt[0].r = {c0[15:11], c0[15:13]};
    pal_nxt[0].g = {c0[10:5],  c0[10:9]};
    pal_nxt[0].b = {c0[4:0],   c0[4:2]};
    pal_nxt[1].r = {c1[15:11], c1[15:13]};
    pal_nxt[1].g = {c1[10:5],  c1[10:9]};
    pal_nxt[1].b = {c1[4:0],   c1[4:2]};

    // two-thirds blends for four-color mode
    s2r = {1'b0, pal_nxt[0].r, 1'b0} + 10'(pal_nxt[1].r);
    s2g = {1'b0, pal_nxt[0].g, 1'b0} + 10'(pal_nxt[1].g);
    s2b = {1'b0, pal_nxt[0].b, 1'b0} + 10'(pal_nxt[1].b);
    s3r = 10'(pal_nxt[0].r) + {1'b0, pal_nxt[1].r, 1'b0};
    s3g = 10'(pal_nxt[0].g) + {1'b0, pal_nxt[1].g, 1'b0};
    s3b = 10'(pal_nxt[0].b) + {1'b0, pal_nxt[1].b, 1'b0};
    // midpoint for three-color mode
    hr  = 9'(pal_nxt[0].r) + 9'(pal_nxt[1].r);
    hg  = 9'(pal_nxt[0].g) + 9'(pal_nxt[1].g);
    hb  = 9'(pal_nxt[0].b) + 9'(pal_nxt[1].b);

    if (three_nxt) begin
      pal_nxt[2].r = hr[8:1];
      pal_nxt[2].g = hg[8:1];
      pal_nxt[2].b = hb[8:1];
      pal_nxt[3]   = '0;
    end else begin
      pal_nxt[2].r = div3(s2r);
      pal_nxt[2].g = div3(s2g);
      pal_nxt[2].b = div3(s2b);
      pal_nxt[3].r = div3(s3r);
      pal_nxt[3].g = div3(s3g);
      pal_nxt[3].b = div3(s3b);
    end

    // DXT5 alpha table
    a0          = blk_lo_r[7:0];
    a1          = blk_lo_r[15:8];
    atab_nxt[0] = a0;
    atab_nxt[1] = a1;
    asum        = '0;
    for (int i = 2; i < 8; i++) begin
      if (a0 > a1) begin
        asum        = 11'(8 - i) * 11'(a0) + 11'(i - 1) * 11'(a1);
        atab_nxt[i] = div7(asum);
      end else if (i < 6) begin
        asum        = 11'(6 - i) * 11'(a0) + 11'(i - 1) * 11'(a1);
        atab_nxt[i] = div5(asum);
      end else if (i == 6) begin
        atab_nxt[i] = 8'd0;
      end else begin
        atab_nxt[i] = 8'd255;
      end
    end
  end

  // ---------------------------------------------------------------
  // Palette register and row sequencer
  // ---------------------------------------------------------------
  dxtbd_pkg::rgb_t pal_r [4];
  logic [7:0]      atab_r [8];
  logic [63:0]     alo_r;
  logic [31:0]     bits_r;
  logic [1:0]      fmt_r;
  logic            three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      row_r     <= 2'd0;
    end else begin
      if (a_take) begin
        b_valid_r <= 1'b1;
      end else if (b_last) begin
        b_valid_r <= 1'b0;
      end
      if (emit) begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      pal_r   <= pal_nxt;
      atab_r  <= atab_nxt;
      alo_r   <= blk_lo_r;
      bits_r  <= cblk[63:32];
      fmt_r   <= block_format_r;
      three_r <= three_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Texel lookup for the current row
  // ---------------------------------------------------------------
  logic [31:0] tex_nxt [4];
  logic [3:0]  t;
  logic [1:0]  idx;
  logic [5:0]  apos;
  logic [3:0]  nib;
  logic [7:0]  alpha;

  always_comb begin
    t     = '0;
    idx   = '0;
    apos  = '0;
    nib   = '0;
    alpha = '0;
    for (int c = 0; c < 4; c++) begin
      t    = {row_r, 2'(c)};
      idx  = bits_r[{t, 1'b0} +: 2];
      apos = 6'd16 + 6'(t) * 6'd3;
      nib  = alo_r[{t, 2'b00} +: 4];
      unique case (fmt_r)
        dxtbd_pkg::FMT_DXT3: alpha = {nib, nib};
        dxtbd_pkg::FMT_DXT5: alpha = atab_r[alo_r[apos +: 3]];
        default:             alpha = (three_r && idx == 2'd3) ? 8'd0 : 8'd255;
      endcase
      tex_nxt[c] = {alpha, pal_r[idx].r, pal_r[idx].g, pal_r[idx].b};
    end
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic [1:0]  out_row_r;
  logic [31:0] out_tex_r [4];
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r  <= row_r;
      out_tex_r  <= tex_nxt;
      out_last_r <= (row_r == 2'd3);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_tex_r[3], out_tex_r[2], out_tex_r[1], out_tex_r[0],
                       out_row_r};

endmodule

[tb/dxt_block_decoder_test.sv]
`timescale 1ns / 1ps

module dxt_block_decoder_test;

  // Format codes, taken from the package
  localparam logic [1:0] FMT_DXT1 = dxtbd_pkg::FMT_DXT1;
  localparam logic [1:0] FMT_DXT3 = dxtbd_pkg::FMT_DXT3;
  localparam logic [1:0] FMT_DXT5 = dxtbd_pkg::FMT_DXT5;
  // Format code that the decoder treats as DXT1
  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_BLOCKS = 40;
  localparam int NUM_DIRECTED = 21;

  // One decoded texel row
  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] texel;
    logic             last;
  } texel_row_t;

  // One directed block; uniform marks blocks whose 16 texels all equal texel
  typedef struct packed {
    logic [1:0]  fmt;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        uniform;
    logic [31:0] texel;
  } directed_block_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         out_tlast;

  texel_row_t rows_due[$];
  logic [1:0] cur_fmt = FMT_DXT1;
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         hold_off_req = 1'b0;

  directed_block_t directed_blocks [NUM_DIRECTED] = '{
    // DXT1 at reset format: all zero, transparent, four-color palette entries, three-color midpoint
    '{FMT_DXT1, 64'h0, 64'h0, 1'b1, 32'hFF000000},
    '{FMT_DXT1, '1, 64'h0, 1'b1, 32'h00000000},
    '{FMT_DXT1, 64'h00000000_0000FFFF, 64'h0, 1'b1, 32'hFFFFFFFF},
    '{FMT_DXT1, 64'h55555555_0000FFFF, '1, 1'b1, 32'hFF000000},
    '{FMT_DXT1, 64'hAAAAAAAA_0000FFFF, 64'h0, 1'b1, 32'hFFAAAAAA},
    '{FMT_DXT1, 64'hFFFFFFFF_0000FFFF, 64'h0, 1'b1, 32'hFF555555},
    '{FMT_DXT1, 64'hAAAAAAAA_FFFF0000, 64'h0, 1'b1, 32'hFF7F7F7F},
    '{FMT_DXT1, 64'h1B1B1B1B_F80007E0, '1, 1'b0, 32'h0},
    '{FMT_DXT1, 64'hE4E4E4E4_001FF800, 64'h0123456789ABCDEF, 1'b0, 32'h0},
    // unused code decodes as DXT1
    '{FMT_UNUSED, '1, 64'h0, 1'b1, 32'h00000000},
    '{FMT_UNUSED, 64'h1B1B1B1B_0000F81F, '1, 1'b0, 32'h0},
    // DXT3 explicit alpha
    '{FMT_DXT3, '1, 64'h0, 1'b1, 32'hFF000000},
    '{FMT_DXT3, 64'h0, '1, 1'b1, 32'h00000000},
    '{FMT_DXT3, 64'h0123456789ABCDEF, 64'hE4E4E4E4_0000FFFF, 1'b0, 32'h0},
    '{FMT_DXT3, 64'hFEDCBA9876543210, 64'hFFFF0000_FFFF0000, 1'b0, 32'h0},
    // DXT5 six- and eight-level alpha
    '{FMT_DXT5, 64'h0, 64'h0, 1'b1, 32'h00000000},
    '{FMT_DXT5, {48'hFFFF_FFFF_FFFF, 8'h00, 8'hFF}, 64'h0, 1'b0, 32'h0},
    '{FMT_DXT5, {48'hFFFF_FFFF_FFFF, 8'hFF, 8'h00}, 64'h0, 1'b1, 32'hFF000000},
    '{FMT_DXT5, {{16{3'b110}}, 8'hC0, 8'h40}, 64'h0, 1'b1, 32'h00000000},
    '{FMT_DXT5, {{16{3'b010}}, 8'h10, 8'hF0}, 64'h1B1B1B1B_F81F07FF, 1'b0, 32'h0},
    '{FMT_DXT5, {48'hFAC688_053977, 8'h00, 8'hFF}, 64'hE4E4E4E4_FFFF0000, 1'b0, 32'h0}
  };

  dxt_block_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("dxt_block_decoder_test failed");
    $finish;
  end

  // Idle cycles before the next request on either side
  function automatic int draw_gap();
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Decode one block into its four expected texel rows
  function automatic void decode_block(input logic [1:0] fmt, input logic [63:0] lo,
                                       input logic [63:0] hi);
    logic [63:0] cblk;
    logic [15:0] c0, c1;
    logic [31:0] idx_bits;
    logic [7:0]  r[4], g[4], b[4], atab[8], alpha[16];
    logic [1:0]  idx;
    bit          three;
    int          a0, a1, t;
    texel_row_t  rw;
    cblk = (fmt == FMT_DXT3 || fmt == FMT_DXT5) ? hi : lo;
    c0 = cblk[15:0];
    c1 = cblk[31:16];
    idx_bits = cblk[63:32];
    three = (c0 <= c1);
    r[0] = {c0[15:11], c0[15:13]};
    g[0] = {c0[10:5], c0[10:9]};
    b[0] = {c0[4:0], c0[4:2]};
    r[1] = {c1[15:11], c1[15:13]};
    g[1] = {c1[10:5], c1[10:9]};
    b[1] = {c1[4:0], c1[4:2]};
    if (!three) begin
      r[2] = 8'((2 * r[0] + r[1]) / 3);
      g[2] = 8'((2 * g[0] + g[1]) / 3);
      b[2] = 8'((2 * b[0] + b[1]) / 3);
      r[3] = 8'((r[0] + 2 * r[1]) / 3);
      g[3] = 8'((g[0] + 2 * g[1]) / 3);
      b[3] = 8'((b[0] + 2 * b[1]) / 3);
    end else begin
      r[2] = 8'((r[0] + r[1]) / 2);
      g[2] = 8'((g[0] + g[1]) / 2);
      b[2] = 8'((b[0] + b[1]) / 2);
      r[3] = '0;
      g[3] = '0;
      b[3] = '0;
    end

    // per-texel alpha
    if (fmt == FMT_DXT5) begin
      a0 = lo[7:0];
      a1 = lo[15:8];
      atab[0] = lo[7:0];
      atab[1] = lo[15:8];
      if (a0 > a1) begin
        for (int i = 2; i < 8; i++) atab[i] = 8'(((8 - i) * a0 + (i - 1) * a1) / 7);
      end else begin
        for (int i = 2; i < 6; i++) atab[i] = 8'(((6 - i) * a0 + (i - 1) * a1) / 5);
        atab[6] = 8'd0;
        atab[7] = 8'd255;
      end
      for (int i = 0; i < 16; i++) alpha[i] = atab[lo[16 + 3 * i +: 3]];
    end else if (fmt == FMT_DXT3) begin
      for (int i = 0; i < 16; i++) alpha[i] = 8'(lo[4 * i +: 4] * 17);
    end else begin
      for (int i = 0; i < 16; i++)
        alpha[i] = (three && idx_bits[2 * i +: 2] == 2'd3) ? 8'd0 : 8'd255;
    end

    for (int row = 0; row < 4; row++) begin
      rw.row = 2'(row);
      rw.last = (row == 3);
      for (int col = 0; col < 4; col++) begin
        t = row * 4 + col;
        idx = idx_bits[2 * t +: 2];
        rw.texel[col] = {alpha[t], r[idx], g[idx], b[idx]};
      end
      rows_due.push_back(rw);
    end
  endfunction

  // Four rows whose texels all hold one known value
  function automatic void expect_uniform(input logic [31:0] texel);
    texel_row_t rw;
    for (int row = 0; row < 4; row++) begin
      rw.row = 2'(row);
      rw.last = (row == 3);
      rw.texel = {4{texel}};
      rows_due.push_back(rw);
    end
  endfunction

  // Random block, biased to hit both color modes and both DXT5 alpha modes
  function automatic void draw_block(input logic [1:0] fmt, output logic [63:0] lo,
                                     output logic [63:0] hi);
    logic [15:0] c0, c1, ctmp;
    logic [7:0]  a0, a1, atmp;
    logic [63:0] color_blk;
    int          pick;
    c0 = 16'($urandom);
    c1 = 16'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0) c1 = c0;
    else if ((pick < 4) == (c0 < c1)) begin
      ctmp = c0;
      c0 = c1;
      c1 = ctmp;
    end
    color_blk = {32'($urandom), c1, c0};
    a0 = 8'($urandom);
    a1 = 8'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0) a1 = a0;
    else if ((pick < 4) == (a0 < a1)) begin
      atmp = a0;
      a0 = a1;
      a1 = atmp;
    end
    unique case (fmt)
      FMT_DXT3: begin
        lo = {32'($urandom), 32'($urandom)};
        hi = color_blk;
      end
      FMT_DXT5: begin
        lo = {32'($urandom), 16'($urandom), a1, a0};
        hi = color_blk;
      end
      default: begin
        lo = color_blk;
        hi = {32'($urandom), 32'($urandom)};
      end
    endcase
  endfunction

  // Write the format register once the decoder has drained
  task automatic select_format(input logic [1:0] fmt);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_fmt = fmt;
  endtask

  // Offer one block and record its expected rows on acceptance
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic uniform, input logic [31:0] texel);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hi, lo};
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    if (uniform) expect_uniform(texel);
    else decode_block(cur_fmt, lo, hi);
  endtask

  // Stimulus
  initial begin
    logic [1:0]  phase_fmt [6];
    logic [63:0] lo, hi;
    phase_fmt = '{FMT_DXT3, FMT_DXT1, FMT_DXT5, FMT_UNUSED, FMT_DXT3, FMT_DXT5};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed blocks
    foreach (directed_blocks[i]) begin
      if (directed_blocks[i].fmt != cur_fmt) select_format(directed_blocks[i].fmt);
      send_block(directed_blocks[i].lo, directed_blocks[i].hi,
                 directed_blocks[i].uniform, directed_blocks[i].texel);
    end

    // random blocks, one format per phase
    foreach (phase_fmt[p]) begin
      select_format(phase_fmt[p]);
      calm = (p == 1);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (p == 2 && n == 5) hold_off_req = 1'b1;
        draw_block(cur_fmt, lo, hi);
        send_block(lo, hi, 1'b0, 32'h0);
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (rows_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("dxt_block_decoder_test passed");
    end else begin
      $display("dxt_block_decoder_test failed");
    end
    $finish;
  end

  // Row receiver and checker
  initial begin
    texel_row_t got, want;
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);

      got.row = out_tdata[1:0];
      got.texel[0] = out_tdata[33:2];
      got.texel[1] = out_tdata[65:34];
      got.texel[2] = out_tdata[97:66];
      got.texel[3] = out_tdata[129:98];
      got.last = out_tlast;
      if (rows_due.size() == 0) begin
        mismatches++;
        $display("%0t: expected no row, got row %0d texels %h", $time, got.row,
                 got.texel);
      end else begin
        want = rows_due.pop_front();
        if (got.row != want.row) begin
          mismatches++;
          $display("%0t: row_index expected %0d got %0d", $time, want.row, got.row);
        end
        for (int col = 0; col < 4; col++) begin
          if (got.texel[col] != want.texel[col]) begin
            mismatches++;
            $display("%0t: row %0d texel_col%0d expected %h got %h", $time, want.row, col,
                     want.texel[col], got.texel[col]);
          end
        end
        if (got.last != want.last) begin
          mismatches++;
          $display("%0t: row %0d last_row expected %b got %b", $time, want.row,
                   want.last, got.last);
        end
      end
    end
  end

endmodule
